/* rtl/core/plcm_pkg.sv */
package plcm_pkg;

    // configuration port
    localparam int unsigned CFG_DATA_W = 33;
    localparam int unsigned CFG_IDX_W  = 2;

    // fixed field widths
    localparam int unsigned RANGE_W    = 16;
    localparam int unsigned SPAN_W     = 33;
    localparam int unsigned NCOL_W     = 5;
    localparam int unsigned ENTRY_W    = 4;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned CHAN_W     = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANGE_MIN  = 2'd0,
        REG_RANGE_MAX  = 2'd1,
        REG_SPAN_SCALE = 2'd2,
        REG_NUM_COLORS = 2'd3
    } t_cfg_reg;

    typedef enum logic {
        OP_MAP   = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } t_color;

endpackage

/* rtl/core/plcm_ram.sv */
module plcm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/plcm_mix.sv */
module plcm_mix (
    input  plcm_pkg::t_color           i_color_a,
    input  plcm_pkg::t_color           i_color_b,
    input  logic [plcm_pkg::FRAC_W-1:0] i_frac,
    output plcm_pkg::t_color           o_color
);

    import plcm_pkg::*;

    localparam int unsigned LANES = 4;
    localparam int unsigned PW    = CHAN_W + FRAC_W + 3;

    logic [CHAN_W-1:0]    lane_a [LANES];
    logic [CHAN_W-1:0]    lane_b [LANES];
    logic [CHAN_W-1:0]    lane_y [LANES];
    logic signed [CHAN_W:0] delta [LANES];
    logic signed [PW-1:0] acc   [LANES];
    logic signed [PW-1:0] quot  [LANES];

    assign lane_a[0] = i_color_a.red;
    assign lane_a[1] = i_color_a.green;
    assign lane_a[2] = i_color_a.blue;
    assign lane_a[3] = i_color_a.alpha;
    assign lane_b[0] = i_color_b.red;
    assign lane_b[1] = i_color_b.green;
    assign lane_b[2] = i_color_b.blue;
    assign lane_b[3] = i_color_b.alpha;

    // per channel: a + floor(((b - a) * frac + half) / 2^16)
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            delta[k] = signed'({1'b0, lane_b[k]}) - signed'({1'b0, lane_a[k]});
            acc[k]   = PW'(delta[k]) * PW'(signed'({1'b0, i_frac}))
                     + PW'(signed'({1'b0, 1'b1, {(FRAC_W-1){1'b0}}}));
            quot[k]  = acc[k] >>> FRAC_W;
            lane_y[k] = lane_a[k] + quot[k][CHAN_W-1:0];
        end
    end

    assign o_color.red   = lane_y[0];
    assign o_color.green = lane_y[1];
    assign o_color.blue  = lane_y[2];
    assign o_color.alpha = lane_y[3];

endmodule

/* rtl/core/piecewise_linear_color_map.sv */
// piecewise linear color map
// maps a signed sample onto a palette of up to MAX_COLORS rgba8888 entries
// input channel: i_valid / o_stall carries one request per cycle while o_stall is low;
//   op 0 maps i_sample to a color, op 1 stores i_entry_color at i_entry_index
// output channel: o_valid / i_stall carries one color per map request;
//   palette writes produce no output
// config port: i_cfg_we with i_cfg_index / i_cfg_data, written while idle
// pipeline: a map request gets its range check at the accepting edge, then
//   span multiply, segment multiply, palette read and channel blend into the
//   output register
// throughput: one request per cycle while i_stall does not hold the output, set by the
//   pipeline stages and the palette's two mirrored read ports; palette writes are
//   applied at the read stage so earlier maps see the old entry and later maps the new one
// reset: synchronous, active low; empties the pipeline and loads the range,
//   span scale and color count defaults; palette contents stay undefined until written
// stall: each stage holds only while the one after it is full and held, so
//   bubbles close up and requests keep entering while a result waits
module piecewise_linear_color_map #(
    parameter int unsigned MAX_COLORS  = 16,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [plcm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [plcm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // request channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_op,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample,
    input  logic [plcm_pkg::ENTRY_W-1:0]      i_entry_index,
    input  logic [31:0]                       i_entry_color,
    // result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_valid_res,
    output logic [plcm_pkg::CHAN_W-1:0]       o_red,
    output logic [plcm_pkg::CHAN_W-1:0]       o_green,
    output logic [plcm_pkg::CHAN_W-1:0]       o_blue,
    output logic [plcm_pkg::CHAN_W-1:0]       o_alpha
);

    import plcm_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_COLORS);
    // sample and bounds compared at a common signed width, one bit of headroom
    localparam int unsigned EXT_W = ((SAMPLE_BITS > RANGE_W) ? SAMPLE_BITS : RANGE_W) + 1;
    localparam int unsigned P_W   = FRAC_W + IDX_W;

    // configuration registers
    logic signed [RANGE_W-1:0] r_range_min;
    logic signed [RANGE_W-1:0] r_range_max;
    logic [SPAN_W-1:0]         r_span_scale;
    logic [NCOL_W-1:0]         r_num_colors;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min  <= '0;
            r_range_max  <= RANGE_W'(32767);
            r_span_scale <= SPAN_W'(131076);
            r_num_colors <= NCOL_W'(2);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_RANGE_MIN:  r_range_min  <= i_cfg_data[RANGE_W-1:0];
                REG_RANGE_MAX:  r_range_max  <= i_cfg_data[RANGE_W-1:0];
                REG_SPAN_SCALE: r_span_scale <= i_cfg_data[SPAN_W-1:0];
                REG_NUM_COLORS: r_num_colors <= i_cfg_data[NCOL_W-1:0];
                default: ;
            endcase
        end
    end

    // last segment index: clamp(num_colors, 2, MAX_COLORS) - 1
    logic [IDX_W-1:0] last_idx;
    always_comb begin
        if (r_num_colors < NCOL_W'(2)) begin
            last_idx = IDX_W'(1);
        end else if (32'(r_num_colors) > MAX_COLORS) begin
            last_idx = IDX_W'(MAX_COLORS - 1);
        end else begin
            last_idx = IDX_W'(r_num_colors - NCOL_W'(1));
        end
    end

    // stage enables, back to front: a stage loads when empty or moving on
    logic en_out, en4, en3, en2, en1;
    logic r_v1, r_v2, r_v3, r_v4;

    assign en_out = !o_valid || !i_stall;
    assign en4    = !r_v4 || en_out;
    assign en3    = !r_v3 || en4;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;
    assign o_stall = !en1;

    // stage 0 logic: range check and offset from range_min
    logic signed [EXT_W-1:0] t_ext, min_ext, max_ext, diff_s;
    logic [32:0]             diff33;
    logic                    in_range, sat0;

    assign t_ext   = EXT_W'(i_sample);
    assign min_ext = EXT_W'(r_range_min);
    assign max_ext = EXT_W'(r_range_max);
    assign diff_s  = t_ext - min_ext;
    assign diff33  = 33'(unsigned'(diff_s));
    assign in_range = (t_ext >= min_ext) && (t_ext <= max_ext);
    // product surely at or above 2^32 when either operand has bit 32 set
    assign sat0 = (r_span_scale[SPAN_W-1] && (diff33 != 33'd0))
               || (diff33[32] && (r_span_scale != '0));

    // stage 1: offset registered for the span multiply
    logic               r_wr1, r_inr1, r_sat1;
    logic [31:0]        r_diff1;
    logic [ENTRY_W-1:0] r_eidx1;
    logic [31:0]        r_ecol1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_wr1   <= (t_op'(i_op) == OP_WRITE);
            r_inr1  <= in_range;
            r_sat1  <= sat0;
            r_diff1 <= diff33[31:0];
            r_eidx1 <= i_entry_index;
            r_ecol1 <= i_entry_color;
        end
    end

    // stage 2: position product offset * span_scale
    logic               r_wr2, r_inr2, r_sat2;
    logic [63:0]        r_prod2;
    logic [ENTRY_W-1:0] r_eidx2;
    logic [31:0]        r_ecol2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_wr2   <= r_wr1;
            r_inr2  <= r_inr1;
            r_sat2  <= r_sat1;
            r_prod2 <= 64'(r_diff1) * 64'(r_span_scale[31:0]);
            r_eidx2 <= r_eidx1;
            r_ecol2 <= r_ecol1;
        end
    end

    // q0.16 position, saturated to all ones
    logic [FRAC_W-1:0] pos_u;
    assign pos_u = (r_sat2 || (r_prod2[63:32] != 32'd0)) ? '1 : r_prod2[31:16];

    // stage 3: segment product position * (num_colors - 1)
    logic               r_wr3, r_inr3;
    logic [P_W-1:0]     r_p3;
    logic [ENTRY_W-1:0] r_eidx3;
    logic [31:0]        r_ecol3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_wr3   <= r_wr2;
            r_inr3  <= r_inr2;
            r_p3    <= P_W'(pos_u) * P_W'(last_idx);
            r_eidx3 <= r_eidx2;
            r_ecol3 <= r_ecol2;
        end
    end

    // palette access: writes and reads both happen here, in request order
    logic [IDX_W-1:0]  seg_idx, addr_a, addr_b, waddr;
    logic [FRAC_W-1:0] seg_frac;
    logic              at_last, pal_we, pal_re, widx_ok;

    assign seg_idx  = r_p3[P_W-1:FRAC_W];
    assign at_last  = (seg_idx >= last_idx);
    assign addr_a   = at_last ? last_idx : seg_idx;
    assign addr_b   = at_last ? last_idx : seg_idx + IDX_W'(1);
    assign seg_frac = at_last ? '0 : r_p3[FRAC_W-1:0];

    // indexes at or beyond the palette depth are dropped
    assign widx_ok = (32'(r_eidx3) < MAX_COLORS);
    assign waddr   = IDX_W'(r_eidx3);
    assign pal_we  = en4 && r_v3 && r_wr3 && widx_ok;
    assign pal_re  = en4 && r_v3 && !r_wr3;

    logic [31:0] rd_a, rd_b;

    // two mirrored copies give the two read ports
    plcm_ram #(
        .WIDTH (32),
        .DEPTH (MAX_COLORS)
    ) u_pal_a (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (waddr),
        .i_wdata (r_ecol3),
        .i_re    (pal_re),
        .i_raddr (addr_a),
        .o_rdata (rd_a)
    );

    plcm_ram #(
        .WIDTH (32),
        .DEPTH (MAX_COLORS)
    ) u_pal_b (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (waddr),
        .i_wdata (r_ecol3),
        .i_re    (pal_re),
        .i_raddr (addr_b),
        .o_rdata (rd_b)
    );

    // stage 4: palette data arrives, blend weight alongside
    logic              r_inr4;
    logic [FRAC_W-1:0] r_frac4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en4) begin
            // write requests end at the palette
            r_v4 <= r_v3 && !r_wr3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_inr4  <= r_inr3;
            r_frac4 <= seg_frac;
        end
    end

    t_color blend;

    plcm_mix u_mix (
        .i_color_a (t_color'(rd_a)),
        .i_color_b (t_color'(rd_b)),
        .i_frac    (r_frac4),
        .o_color   (blend)
    );

    // output register, zero color for out of range samples
    logic   r_valid, r_valid_res;
    t_color r_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en_out) begin
            r_valid <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_valid_res <= r_inr4;
            r_color     <= r_inr4 ? blend : '0;
        end
    end

    assign o_valid     = r_valid;
    assign o_valid_res = r_valid_res;
    assign o_red       = r_color.red;
    assign o_green     = r_color.green;
    assign o_blue      = r_color.blue;
    assign o_alpha     = r_color.alpha;

endmodule

/* sim/plcm_checker.sv */
`timescale 1ns / 1ps

module plcm_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [plcm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [plcm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_req_valid,
    input  logic                            i_req_stall,
    input  logic                            i_op,
    input  logic signed [15:0]              i_sample,
    input  logic [plcm_pkg::ENTRY_W-1:0]    i_entry_index,
    input  logic [31:0]                     i_entry_color,
    input  logic                            i_res_valid,
    input  logic                            i_res_stall,
    input  logic                            i_valid_res,
    input  logic [plcm_pkg::CHAN_W-1:0]     i_red,
    input  logic [plcm_pkg::CHAN_W-1:0]     i_green,
    input  logic [plcm_pkg::CHAN_W-1:0]     i_blue,
    input  logic [plcm_pkg::CHAN_W-1:0]     i_alpha,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_compared
);
    import plcm_pkg::*;

    localparam int unsigned PALETTE_DEPTH = 16;

    typedef struct packed {
        logic   valid_res;
        t_color color;
    } t_color_result;

    t_color_result             expected_colors[$];
    t_color_result             want;
    logic signed [RANGE_W-1:0] range_min;
    logic signed [RANGE_W-1:0] range_max;
    logic [SPAN_W-1:0]         span_scale;
    logic [NCOL_W-1:0]         num_colors;
    logic [31:0]               shade[PALETTE_DEPTH];
    int                        fail_cnt = 0;
    int                        compared_cnt = 0;

    task automatic report(input string msg);
        $display("mismatch at %0t ns, color %0d: %s", $time, compared_cnt, msg);
        fail_cnt++;
    endtask

    // one channel: a + floor(((b - a) * frac + half) / 2^16)
    function automatic logic [CHAN_W-1:0] blend(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b,
                                                input longint frac);
        longint v;
        longint mixed;
        v     = (longint'(b) - longint'(a)) * frac + 32768;
        mixed = longint'(a) + (v >>> FRAC_W);
        return mixed[CHAN_W-1:0];
    endfunction

    function automatic t_color_result map_sample(input logic signed [15:0] s);
        longint        diff;
        longint        u;
        longint        n;
        longint        p;
        longint        seg;
        longint        frac;
        logic [31:0]   lo_c;
        logic [31:0]   hi_c;
        t_color_result r;
        r = '0;
        if (s < range_min || s > range_max)
            return r;
        // position in q0.16, saturated
        diff = longint'(s) - longint'(range_min);
        u    = (diff * longint'(span_scale)) >>> FRAC_W;
        if (u > 65535)
            u = 65535;
        n = longint'(num_colors);
        if (n < 2)
            n = 2;
        if (n > PALETTE_DEPTH)
            n = PALETTE_DEPTH;
        p    = u * (n - 1);
        seg  = p >>> FRAC_W;
        frac = p & 65535;
        if (seg >= n - 1) begin
            lo_c = shade[n-1];
            hi_c = lo_c;
            frac = 0;
        end else begin
            lo_c = shade[seg];
            hi_c = shade[seg+1];
        end
        r.valid_res   = 1'b1;
        r.color.red   = blend(lo_c[31:24], hi_c[31:24], frac);
        r.color.green = blend(lo_c[23:16], hi_c[23:16], frac);
        r.color.blue  = blend(lo_c[15:8],  hi_c[15:8],  frac);
        r.color.alpha = blend(lo_c[7:0],   hi_c[7:0],   frac);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            range_min  = '0;
            range_max  = 16'sd32767;
            span_scale = 33'd131076;
            num_colors = 5'd2;
            expected_colors.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (expected_colors.size() == 0) begin
                    report("color result with no lookup pending");
                end else begin
                    want = expected_colors.pop_front();
                    compared_cnt++;
                    if (i_valid_res !== want.valid_res)
                        report($sformatf("valid_res got %0h expected %0h",
                                         i_valid_res, want.valid_res));
                    if (i_red !== want.color.red)
                        report($sformatf("red got %0h expected %0h", i_red, want.color.red));
                    if (i_green !== want.color.green)
                        report($sformatf("green got %0h expected %0h",
                                         i_green, want.color.green));
                    if (i_blue !== want.color.blue)
                        report($sformatf("blue got %0h expected %0h", i_blue, want.color.blue));
                    if (i_alpha !== want.color.alpha)
                        report($sformatf("alpha got %0h expected %0h",
                                         i_alpha, want.color.alpha));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_RANGE_MIN:  range_min  = i_cfg_data[RANGE_W-1:0];
                    REG_RANGE_MAX:  range_max  = i_cfg_data[RANGE_W-1:0];
                    REG_SPAN_SCALE: span_scale = i_cfg_data[SPAN_W-1:0];
                    REG_NUM_COLORS: num_colors = i_cfg_data[NCOL_W-1:0];
                    default: ;
                endcase
            end
            if (i_req_valid && !i_req_stall) begin
                if (i_op == OP_WRITE)
                    shade[i_entry_index] = i_entry_color;
                else
                    expected_colors.push_back(map_sample(i_sample));
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= expected_colors.size();
        o_compared   <= compared_cnt;
    end

endmodule

/* sim/tb_piecewise_linear_color_map.sv */
`timescale 1ns / 1ps

module tb_piecewise_linear_color_map;
    import plcm_pkg::*;

    // drain padding after the last expected color, lets trailing palette writes finish
    localparam int DRAIN_PAD   = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 72;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_valid       = 1'b0;
    logic                  o_stall;
    logic                  i_op          = 1'b0;
    logic signed [15:0]    i_sample      = '0;
    logic [ENTRY_W-1:0]    i_entry_index = '0;
    logic [31:0]           i_entry_color = '0;
    logic                  o_valid;
    logic                  i_stall       = 1'b0;
    logic                  o_valid_res;
    logic [CHAN_W-1:0]     o_red;
    logic [CHAN_W-1:0]     o_green;
    logic [CHAN_W-1:0]     o_blue;
    logic [CHAN_W-1:0]     o_alpha;

    int fail_count;
    int pending;
    int compared;

    // no random idling on either side while set
    bit steady = 1'b0;

    int cycle_count  = 0;
    int map_count    = 0;
    int write_count  = 0;
    int setting_count = 0;

    // range currently loaded, used to aim samples
    int cur_min = 0;
    int cur_max = 32767;

    piecewise_linear_color_map dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_sample      (i_sample),
        .i_entry_index (i_entry_index),
        .i_entry_color (i_entry_color),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_valid_res   (o_valid_res),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_alpha       (o_alpha)
    );

    // watches both channels and the register port, predicts every color
    plcm_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_req_valid   (i_valid),
        .i_req_stall   (o_stall),
        .i_op          (i_op),
        .i_sample      (i_sample),
        .i_entry_index (i_entry_index),
        .i_entry_color (i_entry_color),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_valid_res   (o_valid_res),
        .i_red         (o_red),
        .i_green       (o_green),
        .i_blue        (o_blue),
        .i_alpha       (o_alpha),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_compared    (compared)
    );

    // 125 MHz clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // watchdog, ends a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d colors still expected",
                     cycle_count, pending);
            $display("status: fail");
            $finish;
        end
    end

    // result side backpressure, about 15 percent of cycles
    always @(posedge i_clk) begin
        i_stall <= !steady && ($urandom_range(99) < 15);
    end

    // one request on the input channel; returns right after the accepting edge
    // so a following request can keep valid high without a gap
    task automatic send_request(input t_op op, input logic [15:0] s,
                                input logic [ENTRY_W-1:0] idx, input logic [31:0] col);
        while (!steady && $urandom_range(99) < 15) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_op          <= op;
        i_sample      <= s;
        i_entry_index <= idx;
        i_entry_color <= col;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        if (op == OP_WRITE)
            write_count++;
        else
            map_count++;
    endtask

    // unused fields carry random bits so they toggle too
    task automatic send_map(input int s);
        logic [31:0] sv;
        sv = s;
        send_request(OP_MAP, sv[15:0], ENTRY_W'($urandom_range(15)), $urandom());
    endtask

    task automatic send_write(input int idx, input logic [31:0] col);
        send_request(OP_WRITE, 16'($urandom_range(65535)), ENTRY_W'(idx), col);
    endtask

    // idle the input, wait for every expected color, then let the pipe empty
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    // writes all four registers on back-to-back edges, only called when idle
    task automatic apply_setting(input int lo, input int hi,
                                 input logic [SPAN_W-1:0] span, input logic [NCOL_W-1:0] ncol);
        logic [31:0] lo_w;
        logic [31:0] hi_w;
        lo_w = lo;
        hi_w = hi;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_RANGE_MIN;
        i_cfg_data  <= {{17{lo_w[15]}}, lo_w[15:0]};
        @(posedge i_clk);
        i_cfg_index <= REG_RANGE_MAX;
        i_cfg_data  <= {{17{hi_w[15]}}, hi_w[15:0]};
        @(posedge i_clk);
        i_cfg_index <= REG_SPAN_SCALE;
        i_cfg_data  <= span;
        @(posedge i_clk);
        i_cfg_index <= REG_NUM_COLORS;
        i_cfg_data  <= {$urandom(), 1'($urandom_range(1))} & ~33'h1f | 33'(ncol);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_min  = lo;
        cur_max  = hi;
        setting_count++;
    endtask

    // scale for a range: floor(2^32 / (hi - lo)), 2^32 for an empty or inverted range
    function automatic logic [SPAN_W-1:0] span_for(input int lo, input int hi);
        longint d;
        d = longint'(hi) - longint'(lo);
        if (d <= 0)
            return 33'h1_0000_0000;
        return SPAN_W'(64'h1_0000_0000 / d);
    endfunction

    // random register set: mostly sane ranges, some inverted, equal or odd spans
    task automatic pick_setting();
        int                lo;
        int                hi;
        int                a;
        int                b;
        int                r;
        logic [SPAN_W-1:0] span;
        logic [NCOL_W-1:0] ncol;
        r = $urandom_range(99);
        if (r < 15) begin
            lo = -32768;
            hi = 32767;
        end else if (r < 25) begin
            // inverted range, nothing maps
            lo = int'($urandom_range(32767));
            hi = lo - 1 - int'($urandom_range(lo + 32767));
        end else if (r < 30) begin
            lo = int'($urandom_range(65535)) - 32768;
            hi = lo;
        end else begin
            a = int'($urandom_range(65535)) - 32768;
            b = int'($urandom_range(65535)) - 32768;
            if (a > b) begin
                lo = b;
                hi = a;
            end else begin
                lo = a;
                hi = b;
            end
            if (lo == hi) begin
                if (hi < 32767)
                    hi++;
                else
                    lo--;
            end
        end
        r = $urandom_range(99);
        if (r < 80)
            span = span_for(lo, hi);
        else if (r < 90)
            span = {1'($urandom_range(1)), 32'($urandom())};
        else
            span = $urandom_range(1) ? 33'h1_0000_0000 : 33'd1;
        if (span == '0)
            span = 33'd1;
        // color count outside 2..16 gets clamped by the block
        if ($urandom_range(99) < 80)
            ncol = NCOL_W'($urandom_range(16, 2));
        else
            ncol = NCOL_W'($urandom_range(31));
        apply_setting(lo, hi, span, ncol);
    endtask

    // sample aimed at the loaded range, with edges and strays mixed in
    function automatic int rand_sample();
        int r;
        r = $urandom_range(99);
        if (cur_min > cur_max || r < 10)
            return int'($urandom_range(65535)) - 32768;
        if (r < 18) begin
            case ($urandom_range(3))
                0: return cur_min;
                1: return cur_max;
                2: return cur_min - 1;
                default: return cur_max + 1;
            endcase
        end
        return cur_min + int'($urandom_range(cur_max - cur_min));
    endfunction

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // palette load, every entry written before any lookup can touch it;
        // first entries alternate black and white for the largest channel steps
        for (int k = 0; k < 16; k++) begin
            if (k < 4 || k == 15)
                send_write(k, (k % 2) ? 32'hffff_ffff : 32'h0000_0000);
            else
                send_write(k, $urandom());
        end

        // reset defaults: 0..32767, two colors
        send_map(-32768);
        send_map(0);
        send_map(32767);
        send_map(16384);
        // overwrite mid stream, later lookup must blend with the new entry
        send_write(1, 32'h80ff_007f);
        send_map(16384);
        settle();

        // full signed range, all sixteen colors
        apply_setting(-32768, 32767, span_for(-32768, 32767), 5'd16);
        send_map(-32768);
        send_map(32767);
        send_map(-1);
        send_map(0);
        send_map(20000);
        settle();

        // inverted range, everything out of range
        apply_setting(100, -100, 33'd1, 5'd5);
        send_map(0);
        send_map(100);
        settle();

        // equal bounds, only that one sample maps, to the first entry
        apply_setting(500, 500, 33'h1_0000_0000, 5'd16);
        send_map(500);
        send_map(501);
        settle();

        // huge scale saturates the position, color count below two
        apply_setting(-1000, 1000, 33'h1_ffff_ffff, 5'd0);
        send_map(-1000);
        send_map(-999);
        send_map(1000);
        settle();

        // minimal scale, color count above sixteen
        apply_setting(-32768, 32767, 33'd1, 5'd31);
        send_map(32767);
        send_map(0);
        settle();

        // random phases, one setting each, palette rewritten now and then
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            steady = (ph == 3);
            pick_setting();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 15)
                    send_write($urandom_range(15), $urandom());
                else
                    send_map(rand_sample());
            end
            settle();
        end
        steady = 1'b0;

        $display("summary: %0d lookups and %0d palette writes over %0d register settings",
                 map_count, write_count, setting_count);
        $display("summary: %0d colors compared in %0d cycles", compared, cycle_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* piecewise_linear_color_map.f */
rtl/core/plcm_pkg.sv
rtl/core/plcm_ram.sv
rtl/core/plcm_mix.sv
rtl/core/piecewise_linear_color_map.sv
sim/plcm_checker.sv
sim/tb_piecewise_linear_color_map.sv
